[src/lbaf_pkg.sv]
package lbaf_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_ENCODE_MODE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 8'd1;

	// opcode fields
	localparam logic [5:0] OP_BL        = 6'h15;
	localparam logic [6:0] OP_PCADDI    = 7'h0C;
	localparam logic [6:0] OP_PCALAU12I = 7'h0D;
	localparam logic [6:0] OP_PCADDU18I = 7'h0F;
	localparam logic [5:0] OP_JIRL      = 6'h13;

	// prior word guard
	localparam logic [31:0] GUARD_LO      = 32'h0015_0000;
	localparam logic [31:0] GUARD_HI      = 32'h2A80_0000;
	localparam logic [31:0] BRANCH_MASK   = 32'hE800_0000;
	localparam logic [31:0] BRANCH_MATCH  = 32'h4000_0000;

	// rewrite masks
	localparam logic [31:0] BL_BASE        = 32'h5400_0000;
	localparam logic [31:0] PCADDI_KEEP    = 32'h1800_001F;
	localparam logic [31:0] PCADDI_SIGN    = 32'h0100_0000;
	localparam logic [31:0] PCALAU_KEEP    = 32'h1A00_001F;
	localparam logic [31:0] PCALAU_SIGN    = 32'h0180_0000;
	localparam logic [19:0] PCALAU_BIAS    = 20'h2_0000;
	localparam logic [19:0] PCALAU_RANGE   = 20'hC_0000;
	localparam logic [31:0] PAIR_HI_KEEP   = 32'h1E00_001F;
	localparam logic [31:0] PAIR_LO_KEEP   = 32'hFC00_03FF;
	localparam logic [39:0] PAIR_ROUND     = 40'h00_0000_8000;

	// window fill codes
	localparam logic [1:0] FILL_EMPTY = 2'd0;
	localparam logic [1:0] FILL_ONE   = 2'd1;
	localparam logic [1:0] FILL_TWO   = 2'd2;

	typedef struct packed {
		logic [31:0] word_out;
		logic        final_word;
	} out_beat_t;

	typedef struct packed {
		logic        encode;
		logic [31:0] prior;
		logic [31:0] middle;
		logic [31:0] next;
		logic [31:0] pc;
	} conv_req_t;

	typedef struct packed {
		logic [31:0] done;
		logic [31:0] next;
	} conv_rsp_t;

endpackage

[src/lbaf_if.sv]
interface lbaf_feed_if import lbaf_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [31:0] word_in;
	logic        end_of_stream;

	modport source (output valid, output word_in, output end_of_stream, input ready);
	modport sink (input valid, input word_in, input end_of_stream, output ready);
endinterface

interface lbaf_result_if import lbaf_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [31:0] word_out;
	logic        final_word;

	modport source (output valid, output word_out, output final_word, input ready);
	modport sink (input valid, input word_out, input final_word, output ready);
endinterface

interface lbaf_cfg_if import lbaf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[src/lbaf_convert.sv]
module lbaf_convert import lbaf_pkg::*; (
	input  conv_req_t req,
	output conv_rsp_t rsp
);

	logic        guard_rej;
	logic        pair_miss;
	logic [31:0] p_word;
	logic [31:0] p_signed;
	logic [31:0] p_page;
	logic [31:0] p_page_signed;
	logic [31:0] bl_src;
	logic [31:0] bl_d;
	logic [31:0] pi_d;
	logic [19:0] pa_chk;
	logic [31:0] pa_d;
	logic [39:0] p_wide;
	logic [39:0] enc_hi;
	logic [39:0] enc_lo;
	logic [39:0] enc_a;
	logic [39:0] enc_sum;
	logic [39:0] enc_fin;
	logic [39:0] dec_a;
	logic [39:0] dec_diff;
	logic [39:0] dec_rnd;

	// prior word guard for bl and pcaddi
	always_comb begin
		guard_rej = ((req.prior - GUARD_LO) > (GUARD_HI - GUARD_LO))
			&& ((req.prior & BRANCH_MASK) != BRANCH_MATCH);
	end

	// pcaddu18i must be followed by a jirl on the same register
	always_comb begin
		pair_miss = (req.next[31:26] != OP_JIRL)
			|| (req.middle[4:0] != req.next[9:5])
			|| ((req.next[4:0] != 5'd1) && (req.next[4:0] != 5'd0));
	end

	// word and page offsets of the middle address
	always_comb begin
		p_word        = {2'b00, req.pc[31:2]};
		p_signed      = req.encode ? p_word : (32'd0 - p_word);
		p_page        = {12'd0, req.pc[31:12]};
		p_page_signed = req.encode ? p_page : (32'd0 - p_page);
		p_wide        = {10'd0, req.pc[31:2]};
	end

	// short forms
	always_comb begin
		bl_src = {6'd0, req.middle[9:0], req.middle[25:10]};
		bl_d   = bl_src + p_signed;
		pi_d   = {12'd0, req.middle[24:5]} + p_signed;
		pa_chk = req.middle[24:5] + PCALAU_BIAS;
		pa_d   = {12'd0, req.middle[24:5]} + p_page_signed;
	end

	// pcaddu18i + jirl, encode direction
	always_comb begin
		enc_hi  = {{4{req.middle[24]}}, req.middle[24:5], 16'd0};
		enc_lo  = {{24{req.next[25]}}, req.next[25:10]};
		enc_a   = enc_hi + enc_lo;
		enc_sum = enc_a + p_wide;
		enc_fin = (enc_sum == 40'd0) ? p_wide : enc_sum;
	end

	// pcaddu18i + jirl, decode direction
	always_comb begin
		dec_a    = {{4{req.next[25]}}, req.next[25:10], req.middle[24:5]};
		dec_diff = (dec_a == p_wide) ? (40'd0 - p_wide) : (dec_a - p_wide);
		dec_rnd  = dec_diff + PAIR_ROUND;
	end

	// select the rewrite by opcode
	always_comb begin
		rsp.done = req.middle;
		rsp.next = req.next;
		if (req.middle[31:26] == OP_BL) begin
			if (!guard_rej) begin
				rsp.done = BL_BASE | {6'd0, bl_d[15:0], 10'd0} | {22'd0, bl_d[25:16]};
			end
		end else if (req.middle[31:25] == OP_PCADDI) begin
			if (!guard_rej) begin
				rsp.done = (req.middle & PCADDI_KEEP) | {7'd0, pi_d[19:0], 5'd0}
					| (pi_d[19] ? PCADDI_SIGN : 32'd0);
			end
		end else if (req.middle[31:25] == OP_PCALAU12I) begin
			if ((pa_chk & PCALAU_RANGE) == 20'd0) begin
				rsp.done = (req.middle & PCALAU_KEEP) | {9'd0, pa_d[17:0], 5'd0}
					| (pa_d[17] ? PCALAU_SIGN : 32'd0);
			end
		end else if (req.middle[31:25] == OP_PCADDU18I) begin
			if (!pair_miss) begin
				if (req.encode) begin
					if (enc_a != 40'd0) begin
						rsp.done = (req.middle & PAIR_HI_KEEP) | {7'd0, enc_fin[19:0], 5'd0};
						rsp.next = (req.next & PAIR_LO_KEEP) | {6'd0, enc_fin[35:20], 10'd0};
					end
				end else begin
					if (dec_a != 40'd0) begin
						rsp.done = (req.middle & PAIR_HI_KEEP) | {7'd0, dec_rnd[35:16], 5'd0};
						rsp.next = (req.next & PAIR_LO_KEEP) | {6'd0, dec_diff[15:0], 10'd0};
					end
				end
			end
		end
	end

endmodule

[src/loongarch_branch_address_filter.sv]
// channel | role | fields                     | handshake
// feed    | sink | word_in, end_of_stream     | valid / ready
// result  | src  | word_out, final_word       | valid / ready
// cfg     | sink | index, data                | valid / ready (always ready)
//
// one feed beat is taken per cycle while feed ready is high; its conversion runs in the accept cycle
// and up to two result beats are pushed into a four-entry output queue.
// a released beat is registered in the queue and offered on the result side behind any beats queued before it.
// feed ready holds while the queue has room for two beats, so a stalled
// result side blocks the feed once three queued beats build up.
// reset empties the window and the queue, mode resets to encode, offset to zero.
module loongarch_branch_address_filter import lbaf_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	lbaf_feed_if.sink      feed,
	lbaf_result_if.source  result,
	lbaf_cfg_if.sink       cfg
);

	logic        encode_q;
	logic [31:0] start_q;
	logic [31:0] prior_q;
	logic [31:0] middle_q;
	logic [1:0]  fill_q;
	logic [31:0] addr_q;

	out_beat_t   queue_q [4];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  count_q;

	conv_req_t   req;
	conv_rsp_t   rsp;
	logic        take;
	logic        pop;
	logic        cfg_take;
	logic [1:0]  push_n;
	out_beat_t   push0;
	out_beat_t   push1;

	// window conversion
	assign req.encode = encode_q;
	assign req.prior  = prior_q;
	assign req.middle = middle_q;
	assign req.next   = feed.word_in;
	assign req.pc     = addr_q;

	lbaf_convert u_convert (
		.req (req),
		.rsp (rsp)
	);

	// handshakes
	assign take     = feed.valid && feed.ready;
	assign pop      = result.valid && result.ready;
	assign cfg_take = cfg.valid && cfg.ready;
	assign feed.ready   = (count_q <= 3'd2);
	assign cfg.ready    = 1'b1;
	assign result.valid = (count_q != 3'd0);
	assign result.word_out   = queue_q[rd_ptr_q].word_out;
	assign result.final_word = queue_q[rd_ptr_q].final_word;

	// beats released by the accepted word
	always_comb begin
		push_n = 2'd0;
		push0  = '{word_out: feed.word_in, final_word: feed.end_of_stream};
		push1  = '{word_out: rsp.next, final_word: 1'b1};
		if (take) begin
			case (fill_q)
				FILL_EMPTY: begin
					push_n = 2'd1;
				end
				FILL_ONE: begin
					push_n = feed.end_of_stream ? 2'd1 : 2'd0;
				end
				default: begin
					push0  = '{word_out: rsp.done, final_word: 1'b0};
					push_n = feed.end_of_stream ? 2'd2 : 2'd1;
				end
			endcase
		end
	end

	// output queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			queue_q[wr_ptr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			queue_q[wr_ptr_q + 2'd1] <= push1;
		end
	end

	// window state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encode_q <= 1'b1;
			start_q  <= 32'd0;
			prior_q  <= 32'd0;
			middle_q <= 32'd0;
			fill_q   <= FILL_EMPTY;
			addr_q   <= 32'd0;
		end else begin
			if (cfg_take) begin
				if (cfg.index == CFG_ENCODE_MODE) begin
					encode_q <= cfg.data[0];
				end else if (cfg.index == CFG_START_OFFSET) begin
					start_q <= {cfg.data[31:2], 2'b00};
					if (fill_q == FILL_EMPTY) begin
						addr_q <= {cfg.data[31:2], 2'b00};
					end
				end
			end
			if (take) begin
				if (feed.end_of_stream) begin
					prior_q  <= 32'd0;
					middle_q <= 32'd0;
					fill_q   <= FILL_EMPTY;
					addr_q   <= start_q;
				end else begin
					case (fill_q)
						FILL_EMPTY: begin
							prior_q <= feed.word_in;
							addr_q  <= addr_q + 32'd4;
							fill_q  <= FILL_ONE;
						end
						FILL_ONE: begin
							middle_q <= feed.word_in;
							fill_q   <= FILL_TWO;
						end
						default: begin
							prior_q  <= rsp.done;
							middle_q <= rsp.next;
							addr_q   <= addr_q + 32'd4;
						end
					endcase
				end
			end
		end
	end

endmodule
